>>> sv/olpu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olpu_pkg: shared types and codes for the ordered list update core
// Operation codes, status codes, the per-cell command and field widths.
// ----------------------------------------------------------------------------
package olpu_pkg;

   localparam int DEPTH_DEFAULT = 32;
   localparam int VALUE_W       = 32;
   localparam int POS_W         = 6;
   localparam int MODE_W        = 3;
   localparam int STATUS_W      = 2;
   localparam int COUNT_W       = 6;
   // wide enough for any count (up to 63) plus one, and any position
   localparam int CMP_W         = 8;

   typedef enum logic [MODE_W-1:0] {
      MODE_INS_FRONT = 3'd0,
      MODE_INS_BACK  = 3'd1,
      MODE_INS_AT    = 3'd2,
      MODE_DEL_FRONT = 3'd3,
      MODE_DEL_BACK  = 3'd4,
      MODE_DEL_AT    = 3'd5,
      MODE_READ_AT   = 3'd6,
      // no operation; always rejected
      MODE_UNUSED    = 3'd7
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_DELETE = 2'd2
   } cell_op_type;

   // broadcast to every cell in the chain
   typedef struct packed {
      cell_op_type               op;
      logic [POS_W-1:0]          index;
      logic signed [VALUE_W-1:0] value;
   } cell_cmd_type;

endpackage
`default_nettype wire

>>> sv/olpu_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olpu_cell: one slot of the list
// Holds one element. Insert: target loads the new value, later cells take the
// left neighbor's. Delete: target and later cells take the right neighbor's.
// ----------------------------------------------------------------------------
module olpu_cell
   import olpu_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  wire logic                      clock,
   input  wire cell_cmd_type              cmd,
   input  wire logic signed [VALUE_W-1:0] prev_value,
   input  wire logic signed [VALUE_W-1:0] next_value,
   output logic signed [VALUE_W-1:0]      value,
   output logic signed [VALUE_W-1:0]      hit_value
);

   localparam logic [POS_W-1:0] MY_INDEX = POS_W'(INDEX);

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (MY_INDEX == cmd.index) begin
               value_in = cmd.value;
            end else if (MY_INDEX > cmd.index) begin
               value_in = prev_value;
            end
         end
         CELL_DELETE: begin
            if (MY_INDEX >= cmd.index) begin
               value_in = next_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value     = value_ff;
   assign hit_value = (MY_INDEX == cmd.index) ? value_ff : '0;

endmodule
`default_nettype wire

>>> sv/ordered_list_positional_update_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_positional_update_core: positional insert/delete/read list
// A row of DEPTH cells holds the list; one command per beat may shift the row.
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    req_mode, req_value, req_position
//   rsp      out  rsp_valid/rsp_ready    rsp_status, rsp_count, rsp_read_value
//
// Affected cells shift or load at the accept edge and the response register loads
// at the same edge, so one beat per cycle while the response side keeps up.
// A new request is taken while the response register is empty or being taken.
// Reset clears the count and the response valid; cell contents stay undefined.
// ----------------------------------------------------------------------------
module ordered_list_positional_update_core
   import olpu_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [MODE_W-1:0]          req_mode,
   input  wire logic signed [VALUE_W-1:0]  req_value,
   input  wire logic [POS_W-1:0]           req_position,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [STATUS_W-1:0]             rsp_status,
   output logic [COUNT_W-1:0]              rsp_count,
   output logic signed [VALUE_W-1:0]       rsp_read_value
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;
   logic signed [VALUE_W-1:0] rsp_read_value_ff;

   logic                      accept;
   cell_cmd_type              cmd;
   status_type                status;
   logic                      read_ok;
   logic signed [VALUE_W-1:0] read_value;
   logic signed [VALUE_W-1:0] hit_or;
   logic [CMP_W-1:0]          pos_ext;
   logic [CMP_W-1:0]          cnt_ext;
   logic                      full;
   logic                      read_range_bad;

   logic signed [VALUE_W-1:0] cell_value [DEPTH];
   logic signed [VALUE_W-1:0] cell_hit   [DEPTH];

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic signed [VALUE_W-1:0] prev_value;
         logic signed [VALUE_W-1:0] next_value;
         if (gi == 0) begin : g_first
            assign prev_value = '0;
         end else begin : g_prev
            assign prev_value = cell_value[gi-1];
         end
         if (gi == DEPTH - 1) begin : g_last
            assign next_value = cell_value[gi];
         end else begin : g_next
            assign next_value = cell_value[gi+1];
         end
         olpu_cell #(
            .INDEX(gi)
         ) u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .prev_value (prev_value),
            .next_value (next_value),
            .value      (cell_value[gi]),
            .hit_value  (cell_hit[gi])
         );
      end
   endgenerate

   always_comb begin
      hit_or = '0;
      for (int i = 0; i < DEPTH; i++) begin
         hit_or = hit_or | cell_hit[i];
      end
   end

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      pos_ext        = CMP_W'(req_position);
      cnt_ext        = CMP_W'(count_ff);
      full           = (count_ff == FULL_COUNT);
      read_range_bad = (pos_ext == '0) || (pos_ext > cnt_ext);
      status         = STATUS_DONE;
      read_ok        = 1'b0;
      count_in       = count_ff;
      cmd.op         = CELL_HOLD;
      cmd.index      = req_position - POS_W'(1);
      cmd.value      = req_value;
      case (mode_type'(req_mode))
         MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_AT: begin
            if (req_mode == MODE_INS_AT &&
                (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1))) begin
               status = STATUS_RANGE;
            end else if (full) begin
               status = STATUS_FULL;
            end else begin
               cmd.op   = CELL_INSERT;
               count_in = count_ff + CNT_W'(1);
               if (req_mode == MODE_INS_FRONT) begin
                  cmd.index = '0;
               end else if (req_mode == MODE_INS_BACK) begin
                  cmd.index = POS_W'(count_ff);
               end
            end
         end
         MODE_DEL_FRONT: begin
            if (count_ff == '0) begin
               status = STATUS_RANGE;
            end else begin
               cmd.op    = CELL_DELETE;
               cmd.index = '0;
               count_in  = count_ff - CNT_W'(1);
            end
         end
         MODE_DEL_BACK: begin
            if (count_ff == '0) begin
               status = STATUS_RANGE;
            end else begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         MODE_DEL_AT: begin
            if (read_range_bad) begin
               status = STATUS_RANGE;
            end else begin
               cmd.op   = CELL_DELETE;
               count_in = count_ff - CNT_W'(1);
            end
         end
         MODE_READ_AT: begin
            if (read_range_bad) begin
               status = STATUS_RANGE;
            end else begin
               read_ok = 1'b1;
            end
         end
         default: begin
            status = STATUS_RANGE;
         end
      endcase
      // hold the row and the count unless a beat is taken
      if (!accept) begin
         cmd.op   = CELL_HOLD;
         count_in = count_ff;
      end
   end

   assign read_value   = read_ok ? hit_or : '0;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff     <= status;
         rsp_count_ff      <= COUNT_W'(count_in);
         rsp_read_value_ff <= read_value;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_read_value = rsp_read_value_ff;

endmodule
`default_nettype wire

>>> sv/olpu_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olpu_checker: port-level checks for the ordered list update core
// Watches both channels and flags response timing and content slips.
// ----------------------------------------------------------------------------
module olpu_checker
   import olpu_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_ready,
   input wire logic [MODE_W-1:0]         req_mode,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire logic [STATUS_W-1:0]       rsp_status,
   input wire logic [COUNT_W-1:0]        rsp_count,
   input wire logic signed [VALUE_W-1:0] rsp_read_value
);

   localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_count) && $stable(rsp_read_value))
      else $error("stalled response changed");

   // every accepted request answers on the next cycle
   a_rsp_next: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("response missing after accepted request");

   // unused mode is always rejected
   a_bad_mode: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == MODE_UNUSED |=> rsp_status == STATUS_RANGE)
      else $error("unused mode not rejected");

   // failed operations read back zero
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_DONE |-> rsp_read_value == '0)
      else $error("nonzero read value on error");

   // the reported count never exceeds the list depth
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> CMP_W'(rsp_count) <= DEPTH_C)
      else $error("count above depth");

endmodule

bind ordered_list_positional_update_core olpu_checker #(
   .DEPTH(DEPTH)
) u_olpu_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_mode       (req_mode),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_status     (rsp_status),
   .rsp_count      (rsp_count),
   .rsp_read_value (rsp_read_value)
);
`default_nettype wire

>>> tb/tb_ordered_list_positional_update_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_ordered_list_positional_update_core: self-checking bench for the list core
// Drives insert, delete and read operations with random gaps and stalls on
// both channels. A shadow list predicts the status, count and read value of
// every beat, and each response is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_ordered_list_positional_update_core;
   import olpu_pkg::*;

   localparam int LIST_DEPTH       = DEPTH_DEFAULT;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int DRAIN_CYCLES     = 4;
   localparam int REPORT_CAP       = 30;
   localparam int MAX_POS          = (1 << POS_W) - 1;
   localparam int SINK_HOLD_CYCLES = 300;

   localparam logic signed [VALUE_W-1:0] VAL_MIN     = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX     = 32'sh7FFF_FFFF;

   typedef struct {
      status_type                status;
      logic [COUNT_W-1:0]        count;
      logic signed [VALUE_W-1:0] read_value;
   } list_result_type;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic [MODE_W-1:0]           req_mode;
   logic signed [VALUE_W-1:0]   req_value;
   logic [POS_W-1:0]            req_position;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic [STATUS_W-1:0]         rsp_status;
   logic [COUNT_W-1:0]          rsp_count;
   logic signed [VALUE_W-1:0]   rsp_read_value;

   // shadow copy of the list contents
   logic signed [VALUE_W-1:0]   shadow_list [LIST_DEPTH];
   int                          shadow_len;
   list_result_type             pending_results [$];

   int                          fail_count = 0;
   bit                          src_idle_en;
   bit                          sink_idle_en;
   // bumped to ask the response side for one long hold
   int                          hold_req_cnt = 0;

   ordered_list_positional_update_core #(
      .DEPTH(LIST_DEPTH)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_value      (req_value),
      .req_position   (req_position),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count),
      .rsp_read_value (rsp_read_value)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // apply one operation to the shadow list and queue the response it gives
   task automatic apply_list_op(input logic [MODE_W-1:0] mode,
                                input logic signed [VALUE_W-1:0] value,
                                input logic [POS_W-1:0] position);
      list_result_type res;
      int              p;
      int              idx;
      p              = position;
      res.status     = STATUS_DONE;
      res.read_value = '0;
      case (mode)
         MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_AT: begin
            // range check on insert at wins over the full check
            if (mode == MODE_INS_AT && (p < 1 || p > shadow_len + 1)) begin
               res.status = STATUS_RANGE;
            end else if (shadow_len >= LIST_DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               if (mode == MODE_INS_FRONT) idx = 0;
               else if (mode == MODE_INS_BACK) idx = shadow_len;
               else idx = p - 1;
               for (int i = shadow_len; i > idx; i--) shadow_list[i] = shadow_list[i-1];
               shadow_list[idx] = value;
               shadow_len++;
            end
         end
         MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_AT: begin
            if (mode == MODE_DEL_AT && (p < 1 || p > shadow_len)) begin
               res.status = STATUS_RANGE;
            end else if (shadow_len == 0) begin
               res.status = STATUS_RANGE;
            end else begin
               if (mode == MODE_DEL_FRONT) idx = 0;
               else if (mode == MODE_DEL_BACK) idx = shadow_len - 1;
               else idx = p - 1;
               for (int i = idx; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
               shadow_len--;
            end
         end
         MODE_READ_AT: begin
            if (p < 1 || p > shadow_len) res.status = STATUS_RANGE;
            else res.read_value = shadow_list[p-1];
         end
         default: res.status = STATUS_RANGE;
      endcase
      res.count = COUNT_W'(shadow_len);
      pending_results.push_back(res);
   endtask

   // drive one beat, hold it until taken, then maybe idle
   task automatic send_op(input logic [MODE_W-1:0] mode,
                          input logic signed [VALUE_W-1:0] value,
                          input logic [POS_W-1:0] position);
      int gap;
      @(negedge clock);
      req_valid    <= 1'b1;
      req_mode     <= mode;
      req_value    <= value;
      req_position <= position;
      do @(posedge clock); while (!req_ready);
      apply_list_op(mode, value, position);
      gap = src_idle_en ? idle_len() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // random operation; weight left after unused, grow and shrink goes to reads
   task automatic send_random(input int grow_pct, input int shrink_pct);
      int                        r;
      int                        hi;
      logic [MODE_W-1:0]         mode;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          position;
      r = $urandom_range(0, 99);
      if (r < 2) mode = MODE_UNUSED;
      else if (r < 2 + grow_pct)
         mode = MODE_W'($urandom_range(MODE_INS_FRONT, MODE_INS_AT));
      else if (r < 2 + grow_pct + shrink_pct)
         mode = MODE_W'($urandom_range(MODE_DEL_FRONT, MODE_DEL_AT));
      else mode = MODE_READ_AT;
      case ($urandom_range(0, 7))
         0:       value = VAL_MIN;
         1:       value = VAL_MAX;
         2:       value = '0;
         3:       value = -1;
         default: value = $urandom;
      endcase
      hi = (mode == MODE_INS_AT) ? shadow_len + 1 : shadow_len;
      if ($urandom_range(0, 9) < 8 && hi >= 1) position = POS_W'($urandom_range(1, hi));
      else position = POS_W'($urandom_range(0, MAX_POS));
      send_op(mode, value, position);
   endtask

   // release the request side and wait until every response is back
   task automatic wait_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_empty_list();
      send_op(MODE_DEL_FRONT, '0, '0);
      send_op(MODE_DEL_BACK, '0, '0);
      send_op(MODE_DEL_AT, '0, 6'd1);
      send_op(MODE_READ_AT, '0, 6'd1);
      send_op(MODE_READ_AT, '0, '0);
      send_op(MODE_INS_AT, 32'sd5, '0);
      send_op(MODE_INS_AT, 32'sd5, 6'd2);
      send_op(MODE_UNUSED, 32'sd5, 6'd1);
   endtask

   task automatic test_edge_values();
      send_op(MODE_INS_FRONT, VAL_MAX, '0);
      send_op(MODE_INS_BACK, VAL_MIN, '0);
      send_op(MODE_INS_AT, '0, 6'd2);
      send_op(MODE_INS_AT, -32'sd1, 6'd4);
      send_op(MODE_INS_AT, 32'sd7, 6'd63);
      for (int i = 1; i <= 4; i++) send_op(MODE_READ_AT, '0, POS_W'(i));
      send_op(MODE_READ_AT, '0, 6'd5);
      send_op(MODE_READ_AT, '0, 6'd63);
      send_op(MODE_DEL_AT, '0, 6'd2);
      send_op(MODE_DEL_AT, '0, '0);
      send_op(MODE_DEL_AT, '0, 6'd4);
      send_op(MODE_DEL_FRONT, '0, '0);
      send_op(MODE_DEL_BACK, '0, '0);
      send_op(MODE_READ_AT, '0, 6'd1);
   endtask

   // grow until full and push past it, then shrink until empty and past it
   task automatic test_fill_and_drain();
      repeat (6) begin
         src_idle_en  = $urandom_range(0, 3) != 0;
         sink_idle_en = $urandom_range(0, 3) != 0;
         while (shadow_len < LIST_DEPTH) send_random(60, 20);
         repeat (20) send_random(60, 20);
         while (shadow_len > 0) send_random(15, 65);
         repeat (20) send_random(15, 65);
      end
   endtask

   task automatic test_random_mix();
      repeat (5) begin
         src_idle_en  = $urandom_range(0, 3) != 0;
         sink_idle_en = $urandom_range(0, 3) != 0;
         repeat (100) send_random(35, 35);
      end
   endtask

   task automatic test_back_to_back();
      src_idle_en  = 1'b0;
      sink_idle_en = 1'b0;
      repeat (200) send_random(40, 35);
   endtask

   // hold the response side off so the core fills and stalls its input
   task automatic test_output_stall();
      wait_drain();
      src_idle_en = 1'b0;
      hold_req_cnt++;
      repeat (40) send_random(40, 30);
      wait_drain();
      src_idle_en  = 1'b1;
      sink_idle_en = 1'b1;
   endtask

   task automatic flag_mismatch(input string what,
                                input logic signed [VALUE_W:0] want_v,
                                input logic signed [VALUE_W:0] got_v);
      fail_count++;
      if (fail_count <= REPORT_CAP)
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
   endtask

   always @(posedge clock) begin : check_results
      list_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_CAP)
               $display("%0t: response with none expected, status %0d count %0d value %0d",
                        $time, rsp_status, rsp_count, rsp_read_value);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               flag_mismatch("status", (VALUE_W+1)'(want.status),
                             (VALUE_W+1)'(rsp_status));
            if (rsp_count !== want.count)
               flag_mismatch("count", (VALUE_W+1)'(want.count),
                             (VALUE_W+1)'(rsp_count));
            if (rsp_read_value !== want.read_value)
               flag_mismatch("read_value", (VALUE_W+1)'(want.read_value),
                             (VALUE_W+1)'(rsp_read_value));
         end
      end
   end

   // response side: long hold on request, otherwise random stalls
   initial begin
      int stall_left;
      int hold_left;
      int hold_seen;
      stall_left = 0;
      hold_left  = 0;
      hold_seen  = 0;
      rsp_ready  = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_req_cnt != hold_seen) begin
            hold_seen = hold_req_cnt;
            hold_left = SINK_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready  <= 1'b1;
            stall_left = sink_idle_en ? idle_len() : 0;
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      wait (!reset);
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_mode     = MODE_INS_FRONT;
      req_value    = '0;
      req_position = '0;
      shadow_len   = 0;
      src_idle_en  = 1'b1;
      sink_idle_en = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_edge_values();
      test_fill_and_drain();
      test_output_stall();
      test_random_mix();
      test_back_to_back();

      wait_drain();
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
`default_nettype wire
